[sv/ratf_pkg.sv]
// Package for the result audit tally: payload structs, codes and constants.
// No dependencies; used by result_audit_tally_fnv_unit.
package ratf_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_HASH  = 2'd1;
	localparam int EXP_COUNT_W = 13;

	// Class codes
	localparam logic [31:0] CLASS_VISIBLE   = 32'd1;
	localparam logic [31:0] CLASS_OCCLUDED  = 32'd2;
	localparam logic [31:0] CLASS_UNCERTAIN = 32'd3;
	localparam int NUM_REASONS = 5;

	// Statistic ids, in dump order
	localparam int STAT_ID_W = 4;
	localparam logic [STAT_ID_W-1:0] STAT_VISIBLE   = 4'd0;
	localparam logic [STAT_ID_W-1:0] STAT_OCCLUDED  = 4'd1;
	localparam logic [STAT_ID_W-1:0] STAT_UNCERTAIN = 4'd2;
	localparam logic [STAT_ID_W-1:0] STAT_REASON1   = 4'd3;
	localparam logic [STAT_ID_W-1:0] STAT_REASON2   = 4'd4;
	localparam logic [STAT_ID_W-1:0] STAT_REASON3   = 4'd5;
	localparam logic [STAT_ID_W-1:0] STAT_REASON4   = 4'd6;
	localparam logic [STAT_ID_W-1:0] STAT_REASON5   = 4'd7;
	localparam logic [STAT_ID_W-1:0] STAT_INVALID   = 4'd8;
	localparam logic [STAT_ID_W-1:0] STAT_CULL_TRIS = 4'd9;
	localparam logic [STAT_ID_W-1:0] STAT_MAX_MIP   = 4'd10;
	localparam logic [STAT_ID_W-1:0] STAT_TEXELS    = 4'd11;
	localparam logic [STAT_ID_W-1:0] STAT_HASH      = 4'd12;
	localparam logic [STAT_ID_W-1:0] STAT_VALID     = 4'd13;

	// FNV-1a 64: prime is 2^40 + 0x1b3
	localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
	localparam int          FNV_PRIME_SHIFT = 40;
	localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;

	// Identity bytes folded per item (four 32-bit words)
	localparam int HASH_BYTES = 16;
	localparam int ROUND_W    = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic [31:0] class_code;
		logic [31:0] reason_code;
		logic [31:0] mip_level;
		logic [31:0] texel_count;
		logic [31:0] ident_low;
		logic [31:0] ident_high;
		logic [31:0] tri_count;
		logic [31:0] slot_index;
		logic        is_last;
	} in_item_t;

	typedef struct packed {
		logic [STAT_ID_W-1:0] stat_id;
		logic [63:0]          stat_value;
		logic                 stat_last;
	} out_item_t;

endpackage

[sv/result_audit_tally_fnv_unit.sv]
// Result audit tally top level: class/reason counters, sums, max mip and a
// byte-serial FNV-1a 64 identity hash with a 14-item statistics dump. Uses ratf_pkg.
//
// An item is taken when start is high and busy is low. The counters, sums and
// slot check settle at that edge; the identity hash then runs one byte round
// per cycle through a single shared xor-multiply unit, 16 rounds, with busy
// held high until they are done. On an item marked last the block then
// emits 14 statistics on res, one per cycle with res_stb high, stat_last set
// on the final one, and clears its tallies; busy stays high in the dump state
// as well. Results cannot be stalled: the receiver must take each one in the
// cycle it is strobed. Configuration writes are taken at any edge with cfg_we
// high and should be made while busy is low.
module result_audit_tally_fnv_unit
	import ratf_pkg::*;
#(
	parameter int MAX_ITEMS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output logic                 res_stb,
	output out_item_t            res
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int INV_W = $clog2(2 * MAX_ITEMS + 1);
	localparam int SUM_W = CNT_W + 2;
	localparam logic [CNT_W-1:0] CAP     = CNT_W'(MAX_ITEMS);
	localparam logic [INV_W-1:0] INV_CAP = INV_W'(2 * MAX_ITEMS);

	// Configuration registers
	logic [EXP_COUNT_W-1:0] exp_count_q;
	logic [63:0]            exp_hash_q;

	// Tally state
	logic [CNT_W-1:0] class_q [3];
	logic [CNT_W-1:0] reason_q [NUM_REASONS];
	logic [INV_W-1:0] invalid_q;
	logic [63:0]      cull_tris_q;
	logic [31:0]      max_mip_q;
	logic [63:0]      texel_q;
	logic [63:0]      hash_q;
	logic [CNT_W-1:0] pos_q;

	// Sequencer
	state_t               state_q, state_d;
	logic [ROUND_W-1:0]   round_q;
	logic [STAT_ID_W-1:0] stat_q;
	logic [127:0]         words_q;
	logic                 last_q;
	logic                 accept;
	logic                 dump_end;

	// Outputs
	logic      res_stb_q;
	out_item_t res_q;

	// Per-item tally logic
	logic             cls_invalid;
	logic             slot_bad;
	logic [INV_W-1:0] inv_step1, inv_step2;

	// Hash round unit
	logic [63:0] hash_x;
	logic [72:0] hash_lo;
	logic [63:0] hash_next;

	// Dump mux
	logic [SUM_W-1:0] class_sum;
	logic             run_valid;
	logic [63:0]      stat_value;

	assign accept   = start && (state_q == ST_IDLE);
	assign dump_end = (state_q == ST_DUMP) && (stat_q == STAT_VALID);

	// Configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_count_q <= '0;
			exp_hash_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_COUNT: exp_count_q <= cfg_data[EXP_COUNT_W-1:0];
				CFG_EXPECTED_HASH:  exp_hash_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Invalid count may step twice per item: bad class, then slot mismatch
	assign cls_invalid = !(item.class_code inside
		{CLASS_VISIBLE, CLASS_OCCLUDED, CLASS_UNCERTAIN});
	assign slot_bad  = item.slot_index != 32'(pos_q);
	assign inv_step1 = (cls_invalid && invalid_q < INV_CAP) ? invalid_q + 1'b1 : invalid_q;
	assign inv_step2 = (slot_bad && inv_step1 < INV_CAP) ? inv_step1 + 1'b1 : inv_step1;

	// One FNV-1a byte round: (h ^ b) * prime, prime split as shift plus 9-bit product
	assign hash_x    = hash_q ^ {56'd0, words_q[7:0]};
	assign hash_lo   = 73'(hash_x) * 73'(FNV_PRIME_LO);
	assign hash_next = (hash_x << FNV_PRIME_SHIFT) + hash_lo[63:0];

	// Tally, hash and clear-after-dump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) class_q[i] <= '0;
			for (int i = 0; i < NUM_REASONS; i++) reason_q[i] <= '0;
			invalid_q   <= '0;
			cull_tris_q <= '0;
			max_mip_q   <= '0;
			texel_q     <= '0;
			hash_q      <= FNV_BASIS;
			pos_q       <= '0;
		end else if (dump_end) begin
			for (int i = 0; i < 3; i++) class_q[i] <= '0;
			for (int i = 0; i < NUM_REASONS; i++) reason_q[i] <= '0;
			invalid_q   <= '0;
			cull_tris_q <= '0;
			max_mip_q   <= '0;
			texel_q     <= '0;
			hash_q      <= FNV_BASIS;
			pos_q       <= '0;
		end else if (accept) begin
			case (item.class_code)
				CLASS_VISIBLE: begin
					if (class_q[0] < CAP) class_q[0] <= class_q[0] + 1'b1;
				end
				CLASS_OCCLUDED: begin
					if (class_q[1] < CAP) class_q[1] <= class_q[1] + 1'b1;
					cull_tris_q <= cull_tris_q + 64'(item.tri_count);
				end
				CLASS_UNCERTAIN: begin
					if (class_q[2] < CAP) class_q[2] <= class_q[2] + 1'b1;
					for (int r = 0; r < NUM_REASONS; r++) begin
						if (item.reason_code == 32'(r + 1) && reason_q[r] < CAP)
							reason_q[r] <= reason_q[r] + 1'b1;
					end
				end
				default: ;
			endcase
			invalid_q <= inv_step2;
			if (item.mip_level > max_mip_q) max_mip_q <= item.mip_level;
			texel_q <= texel_q + 64'(item.texel_count);
			if (pos_q < CAP) pos_q <= pos_q + 1'b1;
		end else if (state_q == ST_HASH) begin
			hash_q <= hash_next;
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			stat_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				round_q <= '0;
				last_q  <= item.is_last;
			end else if (state_q == ST_HASH) begin
				round_q <= round_q + 1'b1;
			end
			if (state_q == ST_DUMP) stat_q <= stat_q + 1'b1;
			else stat_q <= STAT_VISIBLE;
		end
	end

	// Identity words, low byte first
	always_ff @(posedge clk) begin
		if (accept)
			words_q <= {item.slot_index, item.tri_count, item.ident_high, item.ident_low};
		else if (state_q == ST_HASH)
			words_q <= {8'd0, words_q[127:8]};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_HASH;
			end
			ST_HASH: begin
				if (round_q == ROUND_W'(HASH_BYTES - 1))
					state_d = last_q ? ST_DUMP : ST_IDLE;
			end
			ST_DUMP: begin
				if (stat_q == STAT_VALID) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = state_q != ST_IDLE;

	// Statistic select
	assign class_sum = SUM_W'(class_q[0]) + SUM_W'(class_q[1]) + SUM_W'(class_q[2]);
	assign run_valid = (invalid_q == '0) && (32'(class_sum) == 32'(exp_count_q)) &&
		(hash_q == exp_hash_q);

	always_comb begin
		case (stat_q)
			STAT_VISIBLE:   stat_value = 64'(class_q[0]);
			STAT_OCCLUDED:  stat_value = 64'(class_q[1]);
			STAT_UNCERTAIN: stat_value = 64'(class_q[2]);
			STAT_REASON1:   stat_value = 64'(reason_q[0]);
			STAT_REASON2:   stat_value = 64'(reason_q[1]);
			STAT_REASON3:   stat_value = 64'(reason_q[2]);
			STAT_REASON4:   stat_value = 64'(reason_q[3]);
			STAT_REASON5:   stat_value = 64'(reason_q[4]);
			STAT_INVALID:   stat_value = 64'(invalid_q);
			STAT_CULL_TRIS: stat_value = cull_tris_q;
			STAT_MAX_MIP:   stat_value = 64'(max_mip_q);
			STAT_TEXELS:    stat_value = texel_q;
			STAT_HASH:      stat_value = hash_q;
			STAT_VALID:     stat_value = 64'(run_valid);
			default:        stat_value = '0;
		endcase
	end

	// Registered result port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_stb_q <= 1'b0;
		else res_stb_q <= state_q == ST_DUMP;
	end

	always_ff @(posedge clk) begin
		res_q.stat_id    <= stat_q;
		res_q.stat_value <= stat_value;
		res_q.stat_last  <= stat_q == STAT_VALID;
	end

	assign res_stb = res_stb_q;
	assign res     = res_q;

endmodule

[tb/tb_result_audit_tally_fnv_unit.sv]
// Self-checking bench for result_audit_tally_fnv_unit: drives audit runs and checks
// every statistic of each dump against a scoreboard predictor.
// Depends on ratf_pkg and the result_audit_tally_fnv_unit RTL only.
module tb_result_audit_tally_fnv_unit;
	import ratf_pkg::*;

	localparam int ITEM_CAP      = 4096;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 395;
	localparam int RUN_LIMIT     = 12_000_000;

	// Spare register indexes, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// Codes outside the class and reason sets
	localparam logic [31:0] CLASS_UNKNOWN = 32'd0;
	localparam logic [31:0] REASON_NONE   = 32'd0;

	// Uncertain reasons
	localparam logic [31:0] REASON_CAMERA_INSIDE = 32'd1;
	localparam logic [31:0] REASON_NEAR_PLANE    = 32'd2;
	localparam logic [31:0] REASON_PROJECTION    = 32'd3;
	localparam logic [31:0] REASON_RECT          = 32'd4;
	localparam logic [31:0] REASON_MIP           = 32'd5;

	// Payload fill for directed items
	typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

	// Tally predictor and queue of expected statistics
	class audit_scoreboard #(int CAP = 4096);
		logic [12:0] want_count;
		logic [63:0] want_hash;
		int          class_tally [3];
		int          reason_tally [NUM_REASONS];
		int          bad_tally;
		logic [63:0] occluded_tris;
		logic [31:0] peak_mip;
		logic [63:0] texel_sum;
		logic [63:0] ident_hash;
		int          slot_pos;
		out_item_t   stats_due [$];
		int          errors;

		function new();
			want_count = '0;
			want_hash  = '0;
			errors     = 0;
			clear();
		endfunction

		function void clear();
			foreach (class_tally[i]) class_tally[i] = 0;
			foreach (reason_tally[i]) reason_tally[i] = 0;
			bad_tally     = 0;
			occluded_tris = '0;
			peak_mip      = '0;
			texel_sum     = '0;
			ident_hash    = FNV_BASIS;
			slot_pos      = 0;
		endfunction

		function int bump(int v, int lim);
			return (v < lim) ? v + 1 : lim;
		endfunction

		// FNV-1a over the 16 identity bytes, low byte of ident_low first
		function logic [63:0] fold_ident(logic [63:0] h, in_item_t it);
			logic [127:0] bytes;
			logic [63:0]  mult;
			int           b;
			bytes = {it.slot_index, it.tri_count, it.ident_high, it.ident_low};
			mult  = (64'd1 << FNV_PRIME_SHIFT) | {55'd0, FNV_PRIME_LO};
			for (b = 0; b < HASH_BYTES; b++) begin
				h = (h ^ {56'd0, bytes[b*8 +: 8]}) * mult;
			end
			return h;
		endfunction

		function void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				CFG_EXPECTED_COUNT: want_count = data[EXP_COUNT_W-1:0];
				CFG_EXPECTED_HASH:  want_hash  = data;
				default: ;
			endcase
		endfunction

		function void push_stat(logic [STAT_ID_W-1:0] id, logic [63:0] v);
			out_item_t s;
			s.stat_id    = id;
			s.stat_value = v;
			s.stat_last  = (id == STAT_VALID);
			stats_due    = {stats_due, s};
		endfunction

		// Tally one accepted item; on the last one queue the dump and clear
		function void absorb(in_item_t it);
			int k;
			int class_sum;
			case (it.class_code)
				CLASS_VISIBLE: class_tally[0] = bump(class_tally[0], CAP);
				CLASS_OCCLUDED: begin
					class_tally[1] = bump(class_tally[1], CAP);
					occluded_tris  = occluded_tris + 64'(it.tri_count);
				end
				CLASS_UNCERTAIN: begin
					class_tally[2] = bump(class_tally[2], CAP);
					if (it.reason_code inside {[REASON_CAMERA_INSIDE:REASON_MIP]}) begin
						k = int'(it.reason_code - REASON_CAMERA_INSIDE);
						reason_tally[k] = bump(reason_tally[k], CAP);
					end
				end
				default: bad_tally = bump(bad_tally, 2 * CAP);
			endcase
			if (it.mip_level > peak_mip) peak_mip = it.mip_level;
			texel_sum = texel_sum + 64'(it.texel_count);
			if (it.slot_index != 32'(slot_pos)) bad_tally = bump(bad_tally, 2 * CAP);
			ident_hash = fold_ident(ident_hash, it);
			slot_pos   = bump(slot_pos, CAP);
			if (!it.is_last) return;

			class_sum = class_tally[0] + class_tally[1] + class_tally[2];
			push_stat(STAT_VISIBLE,   64'(class_tally[0]));
			push_stat(STAT_OCCLUDED,  64'(class_tally[1]));
			push_stat(STAT_UNCERTAIN, 64'(class_tally[2]));
			for (k = 0; k < NUM_REASONS; k++) push_stat(STAT_REASON1 + 4'(k), 64'(reason_tally[k]));
			push_stat(STAT_INVALID,   64'(bad_tally));
			push_stat(STAT_CULL_TRIS, occluded_tris);
			push_stat(STAT_MAX_MIP,   64'(peak_mip));
			push_stat(STAT_TEXELS,    texel_sum);
			push_stat(STAT_HASH,      ident_hash);
			push_stat(STAT_VALID, (bad_tally == 0 && class_sum == int'(want_count) &&
				ident_hash == want_hash) ? 64'd1 : 64'd0);
			clear();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50) $display("ERROR @%0t: %s", $realtime, msg);
		endtask

		// Compare one strobed statistic with the oldest expectation
		task check_result(out_item_t got);
			out_item_t want;
			if (stats_due.size() == 0) begin
				report($sformatf("statistic id %0d with nothing expected", got.stat_id));
				return;
			end
			want = stats_due.pop_front();
			if (got.stat_id !== want.stat_id)
				report($sformatf("stat_id got %0d want %0d", got.stat_id, want.stat_id));
			if (got.stat_value !== want.stat_value)
				report($sformatf("stat %0d value got %0h want %0h", want.stat_id,
					got.stat_value, want.stat_value));
			if (got.stat_last !== want.stat_last)
				report($sformatf("stat %0d last got %0b want %0b", want.stat_id,
					got.stat_last, want.stat_last));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_item_t             item;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;
	logic                 res_stb;
	out_item_t            res;

	audit_scoreboard #(ITEM_CAP) sb;
	in_item_t run_q [$];

	result_audit_tally_fnv_unit #(.MAX_ITEMS(ITEM_CAP)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_stb   (res_stb),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both handshakes at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.absorb(item);
			if (res_stb) sb.check_result(res);
		end
	end

	// Random payload; clean items keep known classes and the right slot
	function automatic in_item_t rand_item(bit clean, int pos);
		in_item_t    it;
		logic [31:0] slot;
		slot = (pos < ITEM_CAP) ? 32'(pos) : 32'(ITEM_CAP);
		case ($urandom_range(0, clean ? 2 : 4))
			0: it.class_code = CLASS_VISIBLE;
			1: it.class_code = CLASS_OCCLUDED;
			2: it.class_code = CLASS_UNCERTAIN;
			3: it.class_code = $urandom;
			default: it.class_code = $urandom_range(0, 7);
		endcase
		it.reason_code = ($urandom_range(0, 9) != 0) ?
			$urandom_range(REASON_CAMERA_INSIDE, REASON_MIP) : $urandom;
		it.mip_level   = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom;
		it.texel_count = $urandom;
		it.ident_low   = $urandom;
		it.ident_high  = $urandom;
		it.tri_count   = $urandom_range(0, 3) ? $urandom_range(0, 5000) : $urandom;
		it.slot_index  = slot;
		if (!clean && $urandom_range(0, 2) == 0)
			it.slot_index = $urandom_range(0, 1) ? $urandom : slot + 32'd1;
		it.is_last = 1'b0;
		return it;
	endfunction

	function automatic logic [63:0] run_ident_hash();
		logic [63:0] h;
		h = FNV_BASIS;
		foreach (run_q[i]) h = sb.fold_ident(h, run_q[i]);
		return h;
	endfunction

	task automatic build_run(int n, bit clean);
		run_q.delete();
		for (int i = 0; i < n; i++) run_q = {run_q, rand_item(clean, i)};
		run_q[n-1].is_last = 1'b1;
	endtask

	task automatic add_item(logic [31:0] cls, logic [31:0] rsn, fill_t fill);
		in_item_t it;
		it = rand_item(1'b1, run_q.size());
		it.class_code  = cls;
		it.reason_code = rsn;
		if (fill != FILL_RAND) begin
			it.mip_level   = (fill == FILL_ONES) ? '1 : '0;
			it.texel_count = (fill == FILL_ONES) ? '1 : '0;
			it.ident_low   = (fill == FILL_ONES) ? '1 : '0;
			it.ident_high  = (fill == FILL_ONES) ? '1 : '0;
			it.tri_count   = (fill == FILL_ONES) ? '1 : '0;
		end
		run_q = {run_q, it};
	endtask

	// Offer one item after a gap, optionally first letting the block go idle
	task automatic send_item(in_item_t it, int gap, bit after_idle);
		if (gap > 0) begin
			start <= 1'b0;
			if (after_idle) while (busy) @(posedge clk);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_run(bit no_idle);
		foreach (run_q[i])
			send_item(run_q[i], no_idle ? 0 : $urandom_range(0, 6), $urandom_range(0, 1));
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.note_cfg(idx, data);
		@(posedge clk);
	endtask

	// Hold off until the dump has fully arrived and the block is done
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (sb.stats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Point the registers at the current run, sometimes slightly off
	task automatic cfg_match_run(bit perturb);
		logic [63:0] h;
		logic [63:0] cnt;
		h   = run_ident_hash();
		cnt = 64'(run_q.size());
		if (perturb) begin
			if ($urandom_range(0, 1)) cnt = cnt + 64'd1;
			else h = h ^ (64'd1 << $urandom_range(0, 63));
		end
		cfg_write(CFG_EXPECTED_COUNT, cnt);
		cfg_write(CFG_EXPECTED_HASH, h);
		if ($urandom_range(0, 3) == 0)
			cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
	endtask

	task automatic cfg_extremes();
		case ($urandom_range(0, 3))
			0: cfg_write(CFG_EXPECTED_COUNT, '0);
			1: cfg_write(CFG_EXPECTED_COUNT, 64'(ITEM_CAP));
			2: cfg_write(CFG_EXPECTED_COUNT, '1);
			default: cfg_write(CFG_EXPECTED_COUNT, {$urandom, $urandom});
		endcase
		case ($urandom_range(0, 2))
			0: cfg_write(CFG_EXPECTED_HASH, '0);
			1: cfg_write(CFG_EXPECTED_HASH, '1);
			default: cfg_write(CFG_EXPECTED_HASH, {$urandom, $urandom});
		endcase
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int sent;
		int n;
		bit clean;
		int k;

		sb        = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all classes and reasons, unknown codes, field extremes, a bad slot
		cfg_write(CFG_EXPECTED_COUNT, '1);
		cfg_write(CFG_EXPECTED_HASH, '1);
		cfg_write(CFG_SPARE_B, '1);
		run_q.delete();
		add_item(CLASS_VISIBLE, REASON_MIP, FILL_ZERO);
		add_item(CLASS_OCCLUDED, REASON_CAMERA_INSIDE, FILL_ONES);
		add_item(CLASS_UNCERTAIN, REASON_CAMERA_INSIDE, FILL_RAND);
		add_item(CLASS_UNCERTAIN, REASON_NEAR_PLANE, FILL_RAND);
		add_item(CLASS_UNCERTAIN, REASON_PROJECTION, FILL_RAND);
		add_item(CLASS_UNCERTAIN, REASON_RECT, FILL_RAND);
		add_item(CLASS_UNCERTAIN, REASON_MIP, FILL_ZERO);
		add_item(CLASS_UNCERTAIN, REASON_NONE, FILL_RAND);
		add_item(CLASS_UNCERTAIN, '1, FILL_ONES);
		add_item(CLASS_UNKNOWN, REASON_NEAR_PLANE, FILL_RAND);
		add_item('1, REASON_PROJECTION, FILL_ONES);
		add_item(CLASS_UNCERTAIN + 32'd1, REASON_RECT, FILL_RAND);
		add_item(CLASS_VISIBLE, REASON_NONE, FILL_RAND);
		k = run_q.size() - 1;
		run_q[k].slot_index = '1;
		add_item(CLASS_OCCLUDED, REASON_MIP, FILL_ONES);
		run_q[run_q.size()-1].is_last = 1'b1;
		send_run(1'b0);

		// Directed: a one-item run that matches both registers
		wait_quiet();
		run_q.delete();
		add_item(CLASS_VISIBLE, REASON_NONE, FILL_RAND);
		run_q[0].is_last = 1'b1;
		cfg_match_run(1'b0);
		cfg_write(CFG_SPARE_A, {$urandom, $urandom});
		send_run(1'b0);

		// Directed: one item in the wrong slot, registers cleared
		wait_quiet();
		run_q.delete();
		add_item(CLASS_UNCERTAIN, REASON_MIP, FILL_RAND);
		run_q[0].slot_index = 32'd1;
		run_q[0].is_last    = 1'b1;
		cfg_write(CFG_EXPECTED_COUNT, '0);
		cfg_write(CFG_EXPECTED_HASH, '0);
		send_run(1'b0);

		// Random runs: mostly clean with matching registers, the rest noisy
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			n     = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
			clean = ($urandom_range(0, 2) != 0);
			build_run(n, clean);
			if (clean) begin
				wait_quiet();
				cfg_match_run($urandom_range(0, 4) == 0);
			end else if ($urandom_range(0, 3) == 0) begin
				wait_quiet();
				cfg_extremes();
			end
			send_run($urandom_range(0, 3) == 0);
			sent += n;
		end

		wait_quiet();
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
